@@ sv/ctm_pkg.sv @@
// Shared types and constants for the calibration table mapper.
`timescale 1ns / 1ps

package ctm_pkg;

    localparam int DATA_W     = 16;
    localparam int PER_MILLE  = 1000;
    localparam int Y_SCALE    = 10;

    // x / 10 == (x * 52429) >> 19 for all x below 2^18
    localparam logic [15:0] RECIP_Y_SCALE = 16'd52429;
    localparam int          RECIP_SHIFT   = 19;

    // x / 1000 == (x * 68719477) >> 36 for all x below 2^26
    localparam logic [26:0] RECIP_PER_MILLE = 27'd68719477;
    localparam int          RECIP_PM_SHIFT  = 36;
    localparam int          PM_PROD_W       = 54;

    localparam int DIVIDEND_W = 27;
    localparam int DIVISOR_W  = 17;
    localparam int QUOT_W     = 16;
    localparam int FRAC_W     = 11;
    localparam int PROD_W     = 29;

    localparam logic [3:0] FRAC_TOP_BIT  = 4'd9;

    localparam logic [3:0] CFG_ENTRY_COUNT = 4'd0;
    localparam logic [3:0] CFG_INTERPOLATE = 4'd1;

    localparam logic [4:0] ENTRY_COUNT_RST = 5'd2;

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_MAP_XY = 2'd1,
        FN_MAP_YX = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHECK,
        ST_WALK,
        ST_NEAR,
        ST_SPAN,
        ST_DIV_FRAC,
        ST_RECIP,
        ST_ADD,
        ST_SCALE,
        ST_DONE
    } ctm_state_t;

    typedef struct packed {
        logic [4:0] entry_count;
        logic       interpolate_mode;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [3:0]            top_bit;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] mapped;
        logic                     clamped;
    } eng_res_t;

endpackage

@@ sv/ctm_if.sv @@
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface ctm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [3:0]         slot;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic signed [15:0] query;

    modport source (output valid, func, slot, entry_x, entry_y, query, input ready);
    modport sink   (input valid, func, slot, entry_x, entry_y, query, output ready);
endinterface

interface ctm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mapped;
    logic               clamped;

    modport source (output valid, mapped, clamped, input ready);
    modport sink   (input valid, mapped, clamped, output ready);
endinterface

interface ctm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] addr;
    logic [7:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ sv/ctm_ram.sv @@
// Single-port-write, registered-read table memory.
`timescale 1ns / 1ps

module ctm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/ctm_div.sv @@
// Restoring serial divider, one quotient bit per cycle from a chosen top bit.
`timescale 1ns / 1ps

module ctm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ctm_pkg::div_req_t req,
    output ctm_pkg::div_rsp_t rsp
);

    import ctm_pkg::*;

    localparam int SHIFT_W = DIVISOR_W + QUOT_W - 1;

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [QUOT_W-1:0]     quo_reg;
    logic [3:0]            k_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SHIFT_W-1:0]    shifted;
    logic                  fits;

    assign shifted = SHIFT_W'(divisor_reg) << k_reg;
    assign fits    = SHIFT_W'(rem_reg) >= shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg <= (k_reg != 4'd0);
            done_reg <= (k_reg == 4'd0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
            k_reg       <= req.top_bit;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg        <= rem_reg - shifted[DIVIDEND_W-1:0];
                quo_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 4'd1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/ctm_engine.sv @@
// Lookup sequencer: table memories, end checks, segment walk and interpolation.
`timescale 1ns / 1ps

module ctm_engine #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ctm_req_if.sink           req,
    input  ctm_pkg::cfg_t     cfg,
    output ctm_pkg::eng_res_t res,
    input  logic              res_take
);

    import ctm_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    ctm_state_t state_reg, state_next;

    logic                     xy_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] first_c_reg, first_o_reg;
    logic signed [DATA_W-1:0] prev_c_reg, prev_o_reg;
    logic signed [DATA_W-1:0] seg_c1_reg, seg_o1_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     clamped_reg;
    logic                     step_up_reg;
    logic [IW-1:0]            walk_idx_reg;
    logic [CW-1:0]            walk_left_reg;
    logic                     pend_reg;
    logic [DIVISOR_W-1:0]     best_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0]        scaled_reg;
    logic [QUOT_W-1:0]        q10_reg;
    logic                     neg_reg;

    // memory ports
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    logic [IW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] x_rd, y_rd;
    logic signed [DATA_W-1:0] rd_c, rd_o;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // effective entry count
    logic [CW-1:0] n_eff;
    logic [IW-1:0] last_idx;

    // query preparation
    logic signed [19:0]       q_times;
    logic signed [DATA_W-1:0] q_in;
    logic                     accept;

    // end checks
    logic                     up;
    logic signed [DATA_W-1:0] lo_c, lo_o, hi_c, hi_o;
    logic                     clamp_lo, clamp_hi;

    // walk and nearest
    logic                     issue;
    logic                     found;
    logic signed [16:0]       near_diff;
    logic [DIVISOR_W-1:0]     near_mag;

    // interpolation
    logic signed [16:0]       span;
    logic signed [16:0]       q_off;
    logic signed [16:0]       o_diff;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_mag;
    logic [PM_PROD_W-1:0]     pm_full;
    logic signed [16:0]       quo_s;
    logic signed [16:0]       sum;
    logic [DATA_W-1:0]        res_mag;
    logic [31:0]              q10_full;

    ctm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_x_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.entry_x),
        .raddr (mem_raddr),
        .rdata (x_rd)
    );

    ctm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_y_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.entry_y),
        .raddr (mem_raddr),
        .rdata (y_rd)
    );

    ctm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (cfg.entry_count < 5'd2)
        begin
            n_eff = CW'(2);
        end
        else if (32'(cfg.entry_count) > MAX_ENTRIES)
        begin
            n_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = CW'(cfg.entry_count);
        end
    end

    assign last_idx = IW'(n_eff - CW'(1));
    assign accept   = (state_reg == ST_IDLE) && req.valid;

    assign q_times = 20'(req.query) * 20'(Y_SCALE);

    always_comb
    begin
        if (req.func == FN_MAP_XY)
        begin
            q_in = req.query;
        end
        else if (q_times > 20'sd32767)
        begin
            q_in = 16'sh7FFF;
        end
        else if (q_times < -20'sd32768)
        begin
            q_in = 16'sh8000;
        end
        else
        begin
            q_in = q_times[DATA_W-1:0];
        end
    end

    assign rd_c = xy_reg ? x_rd : y_rd;
    assign rd_o = xy_reg ? y_rd : x_rd;

    assign up       = rd_c > first_c_reg;
    assign lo_c     = up ? first_c_reg : rd_c;
    assign lo_o     = up ? first_o_reg : rd_o;
    assign hi_c     = up ? rd_c : first_c_reg;
    assign hi_o     = up ? rd_o : first_o_reg;
    assign clamp_lo = q_reg <= lo_c;
    assign clamp_hi = q_reg >= hi_c;

    assign issue = (walk_left_reg != '0);
    assign found = (q_reg >= prev_c_reg) && (q_reg <= rd_c);

    assign near_diff = 17'(q_reg) - 17'(rd_c);
    assign near_mag  = near_diff[16] ? DIVISOR_W'(-near_diff) : DIVISOR_W'(near_diff);

    assign span   = 17'(seg_c1_reg) - 17'(prev_c_reg);
    assign q_off  = 17'(q_reg) - 17'(prev_c_reg);
    assign o_diff = 17'(seg_o1_reg) - 17'(prev_o_reg);

    assign frac_s    = {1'b0, div_rsp.quotient[FRAC_W-1:0]};
    assign prod_next = PROD_W'(frac_s) * PROD_W'(o_diff);
    assign prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign pm_full   = PM_PROD_W'(prod_mag[DIVIDEND_W-1:0]) * PM_PROD_W'(RECIP_PER_MILLE);

    assign quo_s = {1'b0, scaled_reg};
    assign sum   = 17'(prev_o_reg) + (prod_reg[PROD_W-1] ? -quo_s : quo_s);

    assign res_mag  = res_reg[DATA_W-1] ? DATA_W'(-res_reg) : DATA_W'(res_reg);
    assign q10_full = 32'(res_mag) * 32'(RECIP_Y_SCALE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FN_MAP_XY || req.func == FN_MAP_YX)
                    begin
                        state_next = ST_RD_FIRST;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (clamp_lo || clamp_hi)
                begin
                    state_next = ST_SCALE;
                end
                else if (cfg.interpolate_mode)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_NEAR;
                end
            end
            ST_WALK:
            begin
                if (pend_reg && found)
                begin
                    state_next = ST_SPAN;
                end
                else if (!pend_reg && !issue)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_NEAR:
            begin
                if (!pend_reg && !issue)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SPAN:
            begin
                if (span == 17'sd0)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_DIV_FRAC;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = IW'(req.slot);
        mem_raddr   = '0;
        div_req     = '0;
        res.valid   = 1'b0;
        res.mapped  = res_reg;
        res.clamped = clamped_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                mem_we    = req.valid && (req.func == FN_WRITE)
                            && (32'(req.slot) < MAX_ENTRIES);
            end
            ST_RD_LAST:
            begin
                mem_raddr = last_idx;
            end
            ST_WALK, ST_NEAR:
            begin
                mem_raddr = walk_idx_reg;
            end
            ST_SPAN:
            begin
                div_req.start    = (span != 17'sd0);
                div_req.top_bit  = FRAC_TOP_BIT;
                div_req.dividend = DIVIDEND_W'(q_off) * DIVIDEND_W'(PER_MILLE);
                div_req.divisor  = DIVISOR_W'(span);
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
                if (xy_reg)
                begin
                    res.mapped = neg_reg ? -$signed(q10_reg) : $signed(q10_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            walk_left_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_CHECK:
                begin
                    pend_reg      <= 1'b0;
                    walk_left_reg <= cfg.interpolate_mode ? n_eff - CW'(1) : n_eff;
                end
                ST_WALK, ST_NEAR:
                begin
                    pend_reg <= issue;
                    if (issue)
                    begin
                        walk_left_reg <= walk_left_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    xy_reg      <= (req.func == FN_MAP_XY);
                    q_reg       <= q_in;
                    res_reg     <= '0;
                    clamped_reg <= 1'b0;
                end
            end
            ST_RD_LAST:
            begin
                first_c_reg <= rd_c;
                first_o_reg <= rd_o;
            end
            ST_CHECK:
            begin
                clamped_reg  <= clamp_lo || clamp_hi;
                res_reg      <= (clamp_hi && !clamp_lo) ? hi_o : lo_o;
                prev_c_reg   <= lo_c;
                prev_o_reg   <= lo_o;
                step_up_reg  <= cfg.interpolate_mode ? up : 1'b1;
                best_reg     <= '1;
                if (!cfg.interpolate_mode)
                begin
                    walk_idx_reg <= '0;
                end
                else if (up)
                begin
                    walk_idx_reg <= IW'(1);
                end
                else
                begin
                    walk_idx_reg <= IW'(n_eff - CW'(2));
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    walk_idx_reg <= step_up_reg ? walk_idx_reg + IW'(1)
                                                : walk_idx_reg - IW'(1);
                end
                if (pend_reg)
                begin
                    if (found)
                    begin
                        seg_c1_reg <= rd_c;
                        seg_o1_reg <= rd_o;
                    end
                    else
                    begin
                        prev_c_reg <= rd_c;
                        prev_o_reg <= rd_o;
                    end
                end
            end
            ST_NEAR:
            begin
                if (issue)
                begin
                    walk_idx_reg <= walk_idx_reg + IW'(1);
                end
                if (pend_reg && (near_mag <= best_reg))
                begin
                    best_reg <= near_mag;
                    res_reg  <= rd_o;
                end
            end
            ST_SPAN:
            begin
                if (span == 17'sd0)
                begin
                    res_reg <= prev_o_reg;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_rsp.done)
                begin
                    prod_reg <= prod_next;
                end
            end
            ST_RECIP:
            begin
                scaled_reg <= QUOT_W'(pm_full >> RECIP_PM_SHIFT);
            end
            ST_ADD:
            begin
                res_reg <= sum[DATA_W-1:0];
            end
            ST_SCALE:
            begin
                q10_reg <= QUOT_W'(q10_full >> RECIP_SHIFT);
                neg_reg <= res_reg[DATA_W-1];
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ sv/calibration_table_mapper.sv @@
// Top level: configuration registers, lookup engine and response register.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, slot, entry_x, entry_y, query
//   rsp      out  valid/ready   mapped, clamped
//   cfg      in   valid/ready   addr, data (0 entry_count, 1 interpolate_mode)
//
// One request in flight. A table write goes from ST_IDLE straight to ST_DONE.
// A query reads the first and last table entries before the end check; a
// clamped one then goes through ST_SCALE to ST_DONE. Nearest mode walks all
// n entries through the memory read port. Interpolation walks up to n - 1
// entries, then a 10-step serial divide and a reciprocal scale by 1/1000.
// Reset clears control only; the table is undefined until written. A stalled
// rsp holds the finished response while the next request is taken.
`timescale 1ns / 1ps

module calibration_table_mapper #(
    parameter int MAX_ENTRIES = 16
) (
    input logic       clk,
    input logic       rst_n,
    ctm_req_if.sink   req,
    ctm_rsp_if.source rsp,
    ctm_cfg_if.sink   cfg
);

    import ctm_pkg::*;

    logic [4:0]               entry_count_reg;
    logic                     interpolate_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] mapped_reg;
    logic                     clamped_reg;

    cfg_t     cfg_vals;
    eng_res_t eng_res;
    logic     res_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
            interpolate_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg.data[4:0];
                CFG_INTERPOLATE: interpolate_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_vals.entry_count      = entry_count_reg;
    assign cfg_vals.interpolate_mode = interpolate_reg;

    ctm_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg_vals),
        .res      (eng_res),
        .res_take (res_take)
    );

    assign res_take = eng_res.valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            mapped_reg  <= eng_res.mapped;
            clamped_reg <= eng_res.clamped;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.mapped  = mapped_reg;
    assign rsp.clamped = clamped_reg;

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !eng_res.valid)
        else $error("request taken while a response is pending in the engine");

    a_write_responds: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.func == FN_WRITE) |=> eng_res.valid)
        else $error("table write did not produce a response next cycle");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_res.valid && out_valid_reg && !rsp.ready) |=>
            (eng_res.valid && $stable(eng_res.mapped)))
        else $error("engine dropped a response while the output was blocked");

endmodule
